// ===== rtl/core/gap_buffer_line_editor_macros.svh =====
// Assertion macros used by the gap buffer line editor RTL.
`ifndef GAP_BUFFER_LINE_EDITOR_MACROS_SVH
`define GAP_BUFFER_LINE_EDITOR_MACROS_SVH

// Checked at every rising edge of clk outside reset.
`define GBLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define GBLE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/gble_pkg.sv =====
package gble_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_LEFT   = 3'd1;
    localparam logic [2:0] MODE_RIGHT  = 3'd2;
    localparam logic [2:0] MODE_BACK   = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_BOUNDARY = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] char_in;
        logic [9:0] read_pos;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0]  char_out;
        logic [1:0]  status;
        logic [10:0] text_length;
        logic [10:0] cursor_pos;
    } res_item_t;

    // One transaction between its acceptance and its result.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_char;
        logic [7:0]        ch;
        logic              rd_ok;
        logic [1:0]        status;
        logic [CNT_W-1:0]  text_length;
        logic [CNT_W-1:0]  cursor_pos;
    } stage_t;

endpackage

// ===== rtl/core/gble_store.sv =====
module gble_store
    import gble_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] text_mem [DEPTH];
    logic [7:0] rd_data_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            text_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= text_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/gap_buffer_line_editor.sv =====
// A transaction is registered in s1_reg, then in res_reg. Throughput: one
// transaction per cycle while res_stall is low; set by the single read and
// the single write port of the text store, moved character forwarded past it.
// Reset clears the cursor and length counts and all valid flags at once.
// The text store is not cleared; no entry is read before it has been written.
module gap_buffer_line_editor
    import gble_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res
);

`include "gap_buffer_line_editor_macros.svh"

    logic [CNT_W-1:0]  before_reg, before_next;
    logic [CNT_W-1:0]  after_reg, after_next;
    logic              s1_valid_reg, s1_valid_next;
    stage_t            s1_reg, s1_next;
    logic              fwd_valid_reg, fwd_valid_next;
    logic [7:0]        fwd_data_reg, fwd_data_next;
    logic              res_valid_reg, res_valid_next;
    res_item_t         res_reg, res_next;

    logic              accept;
    logic              s1_adv;
    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  pos_ext;
    logic [CNT_W-1:0]  rd_addr_wide;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic [7:0]        s1_data;
    logic [7:0]        wr_data;
    logic              ram_wr_en;

    assign s1_adv    = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = s1_valid_reg && !s1_adv;
    assign accept    = cmd_valid && !cmd_stall;

    assign len     = before_reg + after_reg;
    assign pos_ext = CNT_W'(cmd.read_pos);

    always_comb
    begin
        before_next  = before_reg;
        after_next   = after_reg;
        rd_addr_wide = '0;
        s1_next      = '0;
        s1_next.ch   = cmd.char_in;
        s1_next.status = ST_DONE;
        unique case (cmd.mode)
            MODE_INSERT:
            begin
                if (len >= CNT_W'(DEPTH))
                begin
                    s1_next.status = ST_FULL;
                end
                else
                begin
                    s1_next.wr_en   = 1'b1;
                    s1_next.wr_addr = before_reg[ADDR_W-1:0];
                    s1_next.wr_char = 1'b1;
                    before_next     = before_reg + 1'b1;
                end
            end
            MODE_LEFT:
            begin
                if (before_reg == '0)
                begin
                    s1_next.status = ST_BOUNDARY;
                end
                else
                begin
                    rd_addr_wide    = before_reg - 1'b1;
                    s1_next.wr_en   = 1'b1;
                    s1_next.wr_addr = ADDR_W'(CNT_W'(DEPTH) - after_reg - 1'b1);
                    before_next     = before_reg - 1'b1;
                    after_next      = after_reg + 1'b1;
                end
            end
            MODE_RIGHT:
            begin
                if (after_reg == '0)
                begin
                    s1_next.status = ST_BOUNDARY;
                end
                else
                begin
                    rd_addr_wide    = CNT_W'(DEPTH) - after_reg;
                    s1_next.wr_en   = 1'b1;
                    s1_next.wr_addr = before_reg[ADDR_W-1:0];
                    before_next     = before_reg + 1'b1;
                    after_next      = after_reg - 1'b1;
                end
            end
            MODE_BACK:
            begin
                if (before_reg == '0)
                begin
                    s1_next.status = ST_BOUNDARY;
                end
                else
                begin
                    before_next = before_reg - 1'b1;
                end
            end
            MODE_READ:
            begin
                if (pos_ext >= len)
                begin
                    s1_next.status = ST_RANGE;
                end
                else
                begin
                    s1_next.rd_ok = 1'b1;
                    if (pos_ext < before_reg)
                    begin
                        rd_addr_wide = pos_ext;
                    end
                    else
                    begin
                        rd_addr_wide = CNT_W'(DEPTH) - after_reg + (pos_ext - before_reg);
                    end
                end
            end
            default:
            begin
                s1_next.status = ST_BOUNDARY;
            end
        endcase
        s1_next.text_length = before_next + after_next;
        s1_next.cursor_pos  = before_next;
    end

    assign rd_addr = rd_addr_wide[ADDR_W-1:0];

    // The character held by the transaction in flight, taken past the store
    // when its write and the next read met at the same address.
    assign s1_data   = fwd_valid_reg ? fwd_data_reg : rd_data;
    assign wr_data   = s1_reg.wr_char ? s1_reg.ch : s1_data;
    assign ram_wr_en = s1_adv && s1_reg.wr_en;

    gble_store u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (s1_reg.wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        res_valid_next = res_valid_reg;
        fwd_valid_next = fwd_valid_reg;
        fwd_data_next  = fwd_data_reg;
        res_next       = res_reg;
        if (s1_adv)
        begin
            s1_valid_next        = 1'b0;
            res_valid_next       = 1'b1;
            res_next.char_out    = s1_reg.rd_ok ? s1_data : 8'd0;
            res_next.status      = s1_reg.status;
            res_next.text_length = 11'(s1_reg.text_length);
            res_next.cursor_pos  = 11'(s1_reg.cursor_pos);
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next  = 1'b1;
            fwd_valid_next = ram_wr_en && (s1_reg.wr_addr == rd_addr);
            fwd_data_next  = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            before_reg    <= '0;
            after_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                before_reg <= before_next;
                after_reg  <= after_next;
            end
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        fwd_data_reg <= fwd_data_next;
        res_reg      <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `GBLE_ASSERT(a_len_bound, (before_reg + after_reg) <= CNT_W'(DEPTH),
        "text length above depth")
    `GBLE_ASSERT(a_refused_no_write,
        s1_valid_reg && (s1_reg.status != ST_DONE) |-> !s1_reg.wr_en,
        "refused transaction writes the store")
    `GBLE_ASSERT(a_insert_step,
        accept && (cmd.mode == MODE_INSERT) && (len < CNT_W'(DEPTH))
            |=> before_reg == $past(before_reg) + 1'b1,
        "insert did not advance the cursor")
    `GBLE_ASSERT(a_cursor_in_text,
        res_valid_reg |-> res_reg.cursor_pos <= res_reg.text_length,
        "cursor beyond end of text")
    `GBLE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !res_valid_reg && !s1_valid_reg,
        "result valid during reset")

endmodule

// ===== tb/tb_gap_buffer_line_editor.sv =====
`timescale 1ns / 100ps

module tb_gap_buffer_line_editor
    import gble_pkg::*;
();

    localparam int QUIET_LIMIT = 2000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res;

    gap_buffer_line_editor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    cmd_item_t   edit_q[$];
    res_item_t   result_q[$];
    res_item_t   fresh_result;
    res_item_t   due_result;

    logic [7:0]  shadow_text [DEPTH];
    int unsigned left_n = 0;
    int unsigned right_n = 0;

    int unsigned gen_len = 0;
    int unsigned gen_cur = 0;

    int          mismatches = 0;
    int          results_seen = 0;
    int          cycle_n = 0;
    int          quiet_n = 0;
    logic        calm;

    assign calm = (cycle_n >= 1000) && (cycle_n < 1600);

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic note_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic predict_edit(input cmd_item_t c, output res_item_t r);
        int unsigned len;
        logic [1:0]  st;
        logic [7:0]  got;
        len = left_n + right_n;
        st = ST_DONE;
        got = 8'd0;
        case (c.mode)
            MODE_INSERT:
            begin
                if (len >= DEPTH)
                    st = ST_FULL;
                else
                begin
                    shadow_text[left_n] = c.char_in;
                    left_n++;
                end
            end
            MODE_LEFT:
            begin
                if (left_n == 0)
                    st = ST_BOUNDARY;
                else
                begin
                    left_n--;
                    shadow_text[DEPTH - right_n - 1] = shadow_text[left_n];
                    right_n++;
                end
            end
            MODE_RIGHT:
            begin
                if (right_n == 0)
                    st = ST_BOUNDARY;
                else
                begin
                    shadow_text[left_n] = shadow_text[DEPTH - right_n];
                    right_n--;
                    left_n++;
                end
            end
            MODE_BACK:
            begin
                if (left_n == 0)
                    st = ST_BOUNDARY;
                else
                    left_n--;
            end
            MODE_READ:
            begin
                if (c.read_pos >= len)
                    st = ST_RANGE;
                else if (c.read_pos < left_n)
                    got = shadow_text[c.read_pos];
                else
                    got = shadow_text[DEPTH - right_n + (c.read_pos - left_n)];
            end
            default:
            begin
                st = ST_BOUNDARY;
            end
        endcase
        r.char_out    = got;
        r.status      = st;
        r.text_length = 11'(left_n + right_n);
        r.cursor_pos  = 11'(left_n);
    endtask

    task automatic add_cmd(input logic [2:0] m, input logic [7:0] ch, input logic [9:0] p);
        cmd_item_t c;
        c.mode     = m;
        c.char_in  = ch;
        c.read_pos = p;
        edit_q.push_back(c);
        case (m)
            MODE_INSERT:
            begin
                if (gen_len < DEPTH)
                begin
                    gen_len++;
                    gen_cur++;
                end
            end
            MODE_LEFT:
            begin
                if (gen_cur > 0)
                    gen_cur--;
            end
            MODE_RIGHT:
            begin
                if (gen_cur < gen_len)
                    gen_cur++;
            end
            MODE_BACK:
            begin
                if (gen_cur > 0)
                begin
                    gen_cur--;
                    gen_len--;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic logic [9:0] pick_read_pos();
        if (gen_len > 0 && $urandom_range(0, 9) < 8)
            return 10'($urandom_range(0, gen_len - 1));
        return 10'($urandom_range(0, 1023));
    endfunction

    task automatic mixed_cmd(input int insert_pct);
        logic [2:0] m;
        int         r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            m = MODE_INSERT;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
                m = MODE_LEFT;
            else if (r < 40)
                m = MODE_RIGHT;
            else if (r < 60)
                m = MODE_BACK;
            else if (r < 95)
                m = MODE_READ;
            else
                m = 3'($urandom_range(5, 7));
        end
        add_cmd(m, 8'($urandom_range(0, 255)), pick_read_pos());
    endtask

    // A transaction is predicted at the very edge that accepts it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                predict_edit(cmd, fresh_result);
                result_q.push_back(fresh_result);
                void'(edit_q.pop_front());
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (edit_q.size() != 0 && (calm || $urandom_range(0, 99) >= 23))
                begin
                    cmd_valid <= 1'b1;
                    cmd       <= edit_q[0];
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            res_stall <= !calm && ($urandom_range(0, 99) < 23);
            if (res_valid && !res_stall)
            begin
                if (result_q.size() == 0)
                begin
                    note_mismatch($sformatf("result with none pending, status %0d",
                                            res.status));
                end
                else
                begin
                    due_result = result_q.pop_front();
                    if (res.char_out !== due_result.char_out)
                        note_mismatch($sformatf("char_out %0d, expected %0d",
                                                res.char_out, due_result.char_out));
                    if (res.status !== due_result.status)
                        note_mismatch($sformatf("status %0d, expected %0d",
                                                res.status, due_result.status));
                    if (res.text_length !== due_result.text_length)
                        note_mismatch($sformatf("text_length %0d, expected %0d",
                                                res.text_length, due_result.text_length));
                    if (res.cursor_pos !== due_result.cursor_pos)
                        note_mismatch($sformatf("cursor_pos %0d, expected %0d",
                                                res.cursor_pos, due_result.cursor_pos));
                end
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_n <= cycle_n + 1;
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet_n <= 0;
        else if (quiet_n >= QUIET_LIMIT)
        begin
            $display("watchdog expired after %0d quiet cycles", quiet_n);
            $display("** gap_buffer_line_editor: FAILED **");
            $finish;
        end
        else
            quiet_n <= quiet_n + 1;
    end

    initial
    begin
        add_cmd(MODE_READ, 8'h00, 10'd0);
        add_cmd(MODE_READ, 8'hFF, 10'd1023);
        add_cmd(MODE_LEFT, 8'h00, 10'd0);
        add_cmd(MODE_RIGHT, 8'h00, 10'd0);
        add_cmd(MODE_BACK, 8'h00, 10'd0);
        add_cmd(3'd5, 8'h00, 10'd0);
        add_cmd(3'd6, 8'hFF, 10'd1023);
        add_cmd(3'd7, 8'h55, 10'd512);
        add_cmd(MODE_INSERT, 8'h00, 10'd0);
        add_cmd(MODE_INSERT, 8'hFF, 10'd0);
        add_cmd(MODE_INSERT, 8'hA5, 10'd1023);
        add_cmd(MODE_INSERT, 8'h5A, 10'd0);
        add_cmd(MODE_READ, 8'h00, 10'd0);
        add_cmd(MODE_READ, 8'h00, 10'd3);
        add_cmd(MODE_READ, 8'h00, 10'd4);
        add_cmd(MODE_LEFT, 8'h00, 10'd0);
        add_cmd(MODE_LEFT, 8'h00, 10'd0);
        add_cmd(MODE_READ, 8'h00, 10'd2);
        add_cmd(MODE_READ, 8'h00, 10'd3);
        add_cmd(MODE_BACK, 8'h00, 10'd0);
        add_cmd(MODE_INSERT, 8'h4C, 10'd0);
        add_cmd(MODE_RIGHT, 8'h00, 10'd0);
        add_cmd(MODE_RIGHT, 8'h00, 10'd0);
        add_cmd(MODE_RIGHT, 8'h00, 10'd0);
        add_cmd(MODE_READ, 8'h00, 10'd1);

        repeat (500) mixed_cmd(45);

        while (gen_len < DEPTH)
            add_cmd(MODE_INSERT, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
        repeat (8) add_cmd(MODE_INSERT, 8'($urandom_range(0, 255)), pick_read_pos());
        repeat (40) add_cmd(MODE_READ, 8'($urandom_range(0, 255)), pick_read_pos());
        repeat (20) add_cmd(MODE_LEFT, 8'($urandom_range(0, 255)), pick_read_pos());
        repeat (3) add_cmd(MODE_INSERT, 8'($urandom_range(0, 255)), pick_read_pos());
        repeat (30) add_cmd(MODE_READ, 8'($urandom_range(0, 255)), pick_read_pos());
        repeat (10) add_cmd(MODE_RIGHT, 8'($urandom_range(0, 255)), pick_read_pos());
        add_cmd(MODE_READ, 8'h00, 10'd0);
        add_cmd(MODE_READ, 8'hFF, 10'd1023);
        repeat (5) add_cmd(MODE_BACK, 8'($urandom_range(0, 255)), pick_read_pos());
        repeat (7) add_cmd(MODE_INSERT, 8'($urandom_range(0, 255)), pick_read_pos());
        repeat (20) add_cmd(MODE_READ, 8'($urandom_range(0, 255)), pick_read_pos());

        while (edit_q.size() < 1975)
            mixed_cmd(25);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (edit_q.size() != 0 || result_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (mismatches == 0)
            $display("** gap_buffer_line_editor: PASSED **");
        else
            $display("** gap_buffer_line_editor: FAILED **");
        $finish;
    end

endmodule

// ===== gap_buffer_line_editor.f =====
+incdir+rtl/core
rtl/core/gble_pkg.sv
rtl/core/gble_store.sv
rtl/core/gap_buffer_line_editor.sv
tb/tb_gap_buffer_line_editor.sv
